@@ hdl/insertion_sort_engine_defines.svh @@
// ---------------------------------------------------------------------------
// insertion_sort_engine assertion macros
// Shorthand for clocked implication checks with reset disable.
// ---------------------------------------------------------------------------
`ifndef INSERTION_SORT_ENGINE_DEFINES_SVH
`define INSERTION_SORT_ENGINE_DEFINES_SVH

// same-cycle implication
`define ISE_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ISE_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/ise_pkg.sv @@
// ---------------------------------------------------------------------------
// ise_pkg
// Shared widths and controller/datapath command and status types.
// ---------------------------------------------------------------------------
`default_nettype none

package ise_pkg;

	localparam int VALUE_W = 32;

	typedef struct packed {
		logic ins;   // insert the incoming value
		logic drop;  // store full, mark the batch
		logic pop;   // head beat taken, shift row down
		logic clr;   // batch done, clear drop mark
	} cmd_t;

	typedef struct packed {
		logic full;
		logic last_out;
	} sts_t;

endpackage

`default_nettype wire

@@ hdl/ise_in_if.sv @@
// ---------------------------------------------------------------------------
// ise_in_if
// Input channel: one batch element per beat, last element flagged.
// ---------------------------------------------------------------------------
`default_nettype none

interface ise_in_if
	import ise_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] value;
	logic                      last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

`default_nettype wire

@@ hdl/ise_out_if.sv @@
// ---------------------------------------------------------------------------
// ise_out_if
// Output channel: one sorted element per beat with batch flags.
// ---------------------------------------------------------------------------
`default_nettype none

interface ise_out_if
	import ise_pkg::*;
();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] sorted_value;
	logic                      final_res;
	logic                      overflow;

	modport source (output valid, output sorted_value, output final_res, output overflow,
		input ready);
	modport sink (input valid, input sorted_value, input final_res, input overflow,
		output ready);
endinterface

`default_nettype wire

@@ hdl/ise_ctrl.sv @@
// ---------------------------------------------------------------------------
// ise_ctrl
// Load/drain sequencer: accepts elements while loading, streams the sorted
// row out while draining.
// ---------------------------------------------------------------------------
`default_nettype none

module ise_ctrl
	import ise_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       in_valid,
	input  wire       in_last,
	output logic      in_ready,
	output logic      out_valid,
	input  wire       out_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_LOAD  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	state_t state_q, state_d;
	logic   in_acc, out_acc;

	assign in_ready  = (state_q == ST_LOAD);
	assign out_valid = (state_q == ST_DRAIN);
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;

	always_comb begin
		cmd.ins  = in_acc && !sts.full;
		cmd.drop = in_acc && sts.full;
		cmd.pop  = out_acc;
		cmd.clr  = out_acc && sts.last_out;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: begin
				if (in_acc && in_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (out_acc && sts.last_out) state_d = ST_LOAD;
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_LOAD;
		else state_q <= state_d;
	end

endmodule

`default_nettype wire

@@ hdl/ise_dpath.sv @@
// ---------------------------------------------------------------------------
// ise_dpath
// Shift-insertion row: each cell compares against the new value and either
// keeps, takes its left neighbor, or takes the new value. Drain shifts the
// row toward cell 0.
// ---------------------------------------------------------------------------
`default_nettype none

module ise_dpath
	import ise_pkg::*;
#(
	parameter int MAX_ELEMENTS = 64
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire cmd_t                 cmd,
	input  wire signed [VALUE_W-1:0]  value,
	output logic signed [VALUE_W-1:0] head_value,
	output logic                      overflow,
	output sts_t                      sts
);

	localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

	logic signed [VALUE_W-1:0] cell_q [MAX_ELEMENTS];
	logic signed [VALUE_W-1:0] cell_d [MAX_ELEMENTS];
	logic signed [VALUE_W-1:0] ins_val [MAX_ELEMENTS];
	logic [MAX_ELEMENTS-1:0]   gt;
	logic [MAX_ELEMENTS-1:0]   take;
	logic [CNT_W-1:0]          count_q;
	logic                      dropped_q;

	// gt marks occupied cells holding a value strictly above the new one
	always_comb begin
		for (int i = 0; i < MAX_ELEMENTS; i++) begin
			gt[i]   = (CNT_W'(i) < count_q) && (cell_q[i] > value);
			take[i] = gt[i] || (count_q == CNT_W'(i));
		end
		ins_val[0] = value;
		for (int i = 1; i < MAX_ELEMENTS; i++) begin
			ins_val[i] = gt[i-1] ? cell_q[i-1] : value;
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_ELEMENTS; i++) begin
			cell_d[i] = cell_q[i];
			if (cmd.ins && take[i]) cell_d[i] = ins_val[i];
		end
		if (cmd.pop) begin
			for (int i = 0; i < MAX_ELEMENTS - 1; i++) begin
				cell_d[i] = cell_q[i+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		cell_q <= cell_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else begin
			if (cmd.ins) count_q <= count_q + CNT_W'(1);
			else if (cmd.pop) count_q <= count_q - CNT_W'(1);
			if (cmd.clr) dropped_q <= 1'b0;
			else if (cmd.drop) dropped_q <= 1'b1;
		end
	end

	assign head_value   = cell_q[0];
	assign overflow     = dropped_q;
	assign sts.full     = (count_q == CNT_W'(MAX_ELEMENTS));
	assign sts.last_out = (count_q == CNT_W'(1));

endmodule

`default_nettype wire

@@ hdl/insertion_sort_engine.sv @@
// ---------------------------------------------------------------------------
// insertion_sort_engine
// Loading: one element per cycle, placed by the shift-insertion row.
// Drain: first sorted beat is offered the cycle after the last element is taken;
// then one beat per cycle while sorted.ready is high, N beats for a batch of N stored elements.
// Input is not taken while draining (row shifts toward the output during drain).
// Reset (arst_n low, asynchronous) empties the row and clears the overflow mark.
// ---------------------------------------------------------------------------
`default_nettype none
`include "insertion_sort_engine_defines.svh"

module insertion_sort_engine
	import ise_pkg::*;
#(
	parameter int MAX_ELEMENTS = 64
) (
	input wire       clk,
	input wire       arst_n,
	ise_in_if.sink   batch,
	ise_out_if.source sorted
);

	cmd_t cmd;
	sts_t sts;

	ise_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (batch.valid),
		.in_last   (batch.last),
		.in_ready  (batch.ready),
		.out_valid (sorted.valid),
		.out_ready (sorted.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ise_dpath #(
		.MAX_ELEMENTS (MAX_ELEMENTS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.value      (batch.value),
		.head_value (sorted.sorted_value),
		.overflow   (sorted.overflow),
		.sts        (sts)
	);

	assign sorted.final_res = sts.last_out;

	`ISE_ASSERT_IMP(a_no_overlap, clk, arst_n, 1'b1, !(batch.ready && sorted.valid),
		"load and drain active together")
	`ISE_ASSERT_NXT(a_last_starts_drain, clk, arst_n,
		batch.valid && batch.ready && batch.last, sorted.valid,
		"no drain after last element")
	`ISE_ASSERT_NXT(a_final_ends_drain, clk, arst_n,
		sorted.valid && sorted.ready && sorted.final_res, batch.ready && !sorted.overflow,
		"batch state not cleared after final beat")
	`ISE_ASSERT_NXT(a_drain_continues, clk, arst_n,
		sorted.valid && sorted.ready && !sorted.final_res, sorted.valid,
		"drain stopped before final beat")

endmodule

`default_nettype wire

@@ tb/sv/insertion_sort_engine_tb.sv @@
// ---------------------------------------------------------------------------
// insertion_sort_engine_tb
// Streams batches of signed values into the sort engine and checks every
// sorted beat, with its final and overflow marks, against a behavioral
// insertion sort kept in step with the accepted input beats.
// ---------------------------------------------------------------------------
`default_nettype none

module insertion_sort_engine_tb;
	import ise_pkg::*;

	localparam int CAPACITY   = 64;
	localparam int QUIET_MAX  = 1000;
	localparam int TAIL_CYCLES = 20;

	localparam logic signed [VALUE_W-1:0] VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
	localparam logic signed [VALUE_W-1:0] VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic                      last;
		int unsigned               gap;
		bit                        hold;
	} element_t;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic                      final_res;
		logic                      overflow;
	} sorted_beat_t;

	logic clk;
	logic arst_n;

	ise_in_if  in_ch ();
	ise_out_if out_ch ();

	insertion_sort_engine u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.batch  (in_ch),
		.sorted (out_ch)
	);

	element_t     pending[$];
	sorted_beat_t sorted_due[$];

	logic signed [VALUE_W-1:0] row[CAPACITY];
	int unsigned row_count;
	bit          row_dropped;

	bit          in_taken;
	bit          out_taken;
	bit          gaps_on;
	bit          stalls_on;
	int unsigned idle_run;
	int unsigned stall_left;
	int unsigned quiet;
	int unsigned errors;
	int unsigned item_total;
	int unsigned batch_idx;
	int unsigned batch_len;
	element_t    head;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// behavioral sort: stable insertion, emit whole row on the last element
	task automatic sort_element(input logic signed [VALUE_W-1:0] v, input logic is_last);
		int unsigned pos;
		sorted_beat_t b;
		if (row_count < CAPACITY) begin
			pos = row_count;
			while (pos > 0 && v < row[pos-1]) begin
				row[pos] = row[pos-1];
				pos--;
			end
			row[pos] = v;
			row_count++;
		end else begin
			row_dropped = 1'b1;
		end
		if (is_last) begin
			for (int k = 0; k < row_count; k++) begin
				b.value     = row[k];
				b.final_res = (k + 1 == row_count);
				b.overflow  = row_dropped;
				sorted_due.push_back(b);
			end
			row_count   = 0;
			row_dropped = 1'b0;
		end
	endtask

	task automatic push_element(input logic signed [VALUE_W-1:0] v, input logic is_last,
		input bit hold);
		element_t e;
		e.value = v;
		e.last  = is_last;
		e.gap   = gaps_on ? $urandom_range(7, 0) : 0;
		e.hold  = hold;
		pending.push_back(e);
		item_total++;
	endtask

	function automatic logic signed [VALUE_W-1:0] pick_value();
		case ($urandom_range(3, 0))
			0, 1: return $urandom;
			2: return $urandom_range(8, 0) - 4;
			default: begin
				case ($urandom_range(3, 0))
					0: return VAL_MIN;
					1: return VAL_MAX;
					2: return '0;
					default: return '1;
				endcase
			end
		endcase
	endfunction

	// input driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_ch.valid || in_taken) begin
				if (pending.size() != 0 && idle_run >= pending[0].gap
					&& !(pending[0].hold && sorted_due.size() != 0)) begin
					head = pending.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.value <= head.value;
					in_ch.last  <= head.last;
					idle_run = 0;
				end else begin
					in_ch.valid <= 1'b0;
					idle_run++;
				end
			end
		end
	end

	// output sink
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_taken)
				stall_left = stalls_on ? $urandom_range(7, 0) : 0;
			if (stall_left != 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		sorted_beat_t exp_b;
		in_taken  <= in_ch.valid && in_ch.ready;
		out_taken <= out_ch.valid && out_ch.ready;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				sort_element(in_ch.value, in_ch.last);
			if (out_ch.valid && out_ch.ready) begin
				if (sorted_due.size() == 0) begin
					$display("%0t: unexpected beat sorted_value %0d final_res %0b overflow %0b",
						$time, out_ch.sorted_value, out_ch.final_res, out_ch.overflow);
					errors++;
				end else begin
					exp_b = sorted_due.pop_front();
					if (out_ch.sorted_value !== exp_b.value) begin
						$display("%0t: sorted_value expected %0d actual %0d",
							$time, exp_b.value, out_ch.sorted_value);
						errors++;
					end
					if (out_ch.final_res !== exp_b.final_res) begin
						$display("%0t: final_res expected %0b actual %0b",
							$time, exp_b.final_res, out_ch.final_res);
						errors++;
					end
					if (out_ch.overflow !== exp_b.overflow) begin
						$display("%0t: overflow expected %0b actual %0b",
							$time, exp_b.overflow, out_ch.overflow);
						errors++;
					end
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_MAX) begin
				$display("%0t: no beat for %0d cycles", $time, QUIET_MAX);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		in_ch.valid  = 1'b0;
		in_ch.value  = '0;
		in_ch.last   = 1'b0;
		out_ch.ready = 1'b0;
		in_taken     = 1'b0;
		out_taken    = 1'b0;
		row_count    = 0;
		row_dropped  = 1'b0;
		idle_run     = 0;
		stall_left   = 0;
		quiet        = 0;
		errors       = 0;
		item_total   = 0;
		gaps_on      = 1'b0;
		stalls_on    = 1'b0;
		arst_n       = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: single element at each extreme, mixed extremes, duplicates
		push_element(VAL_MIN, 1'b1, 1'b0);
		push_element(VAL_MAX, 1'b0, 1'b0);
		push_element(VAL_MIN, 1'b0, 1'b0);
		push_element('0, 1'b0, 1'b0);
		push_element('1, 1'b0, 1'b0);
		push_element(32'sh5555_5555, 1'b0, 1'b0);
		push_element(32'shAAAA_AAAA, 1'b0, 1'b0);
		push_element(1, 1'b0, 1'b0);
		push_element(VAL_MAX, 1'b1, 1'b0);
		push_element(5, 1'b0, 1'b1);
		push_element(3, 1'b0, 1'b0);
		push_element(5, 1'b0, 1'b0);
		push_element(3, 1'b0, 1'b0);
		push_element(-7, 1'b0, 1'b0);
		push_element(5, 1'b1, 1'b0);
		push_element(VAL_MAX, 1'b1, 1'b0);
		for (int i = 0; i < 4; i++)
			push_element(i - 2, i == 3, 1'b0);
		while (pending.size() != 0) @(posedge clk);

		// random batches; a few fill or overrun the store
		batch_idx = 0;
		while (item_total < 320) begin
			case (batch_idx)
				2: batch_len = CAPACITY;
				5: batch_len = CAPACITY + 1;
				9: batch_len = CAPACITY + 6;
				default: batch_len = ($urandom_range(19, 0) == 0) ?
					$urandom_range(CAPACITY + 6, CAPACITY - 4) : $urandom_range(12, 1);
			endcase
			gaps_on   = $urandom_range(3, 0) != 0;
			stalls_on = $urandom_range(3, 0) != 0;
			for (int i = 0; i < batch_len; i++)
				push_element(pick_value(), i == batch_len - 1,
					i == 0 && (batch_idx == 1 || $urandom_range(4, 0) == 0));
			batch_idx++;
			while (pending.size() > 8) @(posedge clk);
		end

		while (pending.size() != 0 || in_ch.valid) @(posedge clk);
		while (sorted_due.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
